FILE: rtl/frame_bit_field_access_assert.svh
// Assertion macros used by the frame bit field access sequencer.
// Expect clk and rst_n in the scope of use.
`ifndef FRAME_BIT_FIELD_ACCESS_ASSERT_SVH
`define FRAME_BIT_FIELD_ACCESS_ASSERT_SVH

// Same-cycle implication.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fba_pkg.sv
// Package for the frame bit field access block: types, codes and constants.
// No dependencies.
package fba_pkg;

    localparam int FRAME_BYTES_DEF    = 64;
    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int BYTE_W             = 7;   // byte number of a bit position
    localparam int LIM_W              = 13;  // holds a byte count up to 8191
    localparam int POS_W              = 10;  // bit position incl. field end
    localparam logic [6:0] FRAME_LEN_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_READ = 2'd1,
        ACT_GET  = 2'd2,
        ACT_SET  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // sequencer to bit slice unit
    typedef struct packed {
        logic       init;   // clear accumulator, load value shifter
        logic       proc;   // a byte from the store is on rd_data
        logic       get;    // extract (1) or insert (0)
        logic [2:0] sh;     // byte bit index of the last field bit in this byte
        logic [3:0] n;      // field bits in this byte, 1..8
        logic       inlim;  // byte lies inside the frame
    } ctl_t;

endpackage

FILE: rtl/fba_store.sv
// Frame byte store: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module fba_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fba_slice.sv
// Bit slice unit: shifts field bits in or out one byte-sized digit a cycle.
// Depends on fba_pkg.
module fba_slice
    import fba_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  logic                 clk,
    input  ctl_t                 ctl,
    input  logic [((MAX_FIELD_BITS > 8) ? MAX_FIELD_BITS : 8)-1:0] init_value,
    input  logic [7:0]           rd_data,
    output logic [7:0]           wr_data,
    output logic [31:0]          read_data
);

    localparam int ACC_W = (MAX_FIELD_BITS > 8) ? MAX_FIELD_BITS : 8;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    val_reg, val_next;
    logic [7:0]          mask8;
    logic [7:0]          bits;
    logic [7:0]          wmask;
    logic [7:0]          ins;
    logic [ACC_W+31:0]   acc_wide;

    assign mask8 = 8'hff >> (4'd8 - ctl.n);
    assign bits  = ctl.inlim ? ((rd_data >> ctl.sh) & mask8) : 8'd0;
    assign wmask = mask8 << ctl.sh;
    assign ins   = (val_reg[7:0] & mask8) << ctl.sh;
    assign wr_data = (rd_data & ~wmask) | ins;

    always_comb
    begin
        acc_next = acc_reg;
        val_next = val_reg;
        if (ctl.init)
        begin
            acc_next = '0;
            val_next = init_value;
        end
        else if (ctl.proc)
        begin
            if (ctl.get)
            begin
                acc_next = (acc_reg << ctl.n) | ACC_W'(bits);
            end
            else
            begin
                val_next = val_reg >> ctl.n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        val_reg <= val_next;
    end

    assign acc_wide  = {32'd0, acc_reg};
    assign read_data = ctl.get ? acc_wide[31:0] : 32'd0;

endmodule

FILE: rtl/fba_seq.sv
// Sequencer: walks the stored bytes a field touches, one per cycle,
// and drives the store ports and the bit slice unit. Depends on fba_pkg and frame_bit_field_access_assert.svh.
module fba_seq
    import fba_pkg::*;
#(
    parameter int FRAME_BYTES    = FRAME_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  action,
    input  logic [5:0]  byte_index,
    input  logic [8:0]  bit_offset,
    input  logic [5:0]  field_length,
    input  logic [6:0]  frame_length,
    output logic        busy,
    output logic        done,
    output ctl_t        ctl,
    output logic        rd_en,
    output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] rd_addr,
    output logic        wr_en,
    output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] wr_addr
);

`include "frame_bit_field_access_assert.svh"

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [LIM_W-1:0] FB   = LIM_W'(FRAME_BYTES);
    localparam logic [6:0]       MAXL = 7'(MAX_FIELD_BITS);

    state_t state_reg, state_next;

    logic [BYTE_W-1:0] cur_reg, cur_next;
    logic [BYTE_W-1:0] stop_reg, stop_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic [2:0]        slo_reg, slo_next;
    logic [2:0]        elo_reg, elo_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic              get_reg, get_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [2:0]        s1_sh_reg, s1_sh_next;
    logic [3:0]        s1_n_reg, s1_n_next;
    logic              s1_inlim_reg, s1_inlim_next;
    logic [AW-1:0]     s1_addr_reg, s1_addr_next;

    action_t           act;
    logic              accept;
    logic              is_byte;
    logic              is_get;
    logic [6:0]        len_clamp;
    logic [6:0]        len_eff;
    logic [POS_W-1:0]  pos0;
    logic [POS_W-1:0]  pos_end;
    logic [LIM_W-1:0]  fl13;
    logic [LIM_W-1:0]  lim_in;

    logic [2:0]        lo;
    logic [2:0]        hi;
    logic [3:0]        n_cur;
    logic [2:0]        sh_cur;
    logic              inlim_cur;
    logic [AW+BYTE_W-1:0] addr_wide;
    logic [AW-1:0]     addr_cur;

    // item decode at accept
    assign act       = action_t'(action);
    assign accept    = start && (state_reg == ST_IDLE || state_reg == ST_DONE);
    assign is_byte   = (act == ACT_LOAD) || (act == ACT_READ);
    assign is_get    = (act == ACT_READ) || (act == ACT_GET);
    assign len_clamp = ({1'b0, field_length} > MAXL) ? MAXL : {1'b0, field_length};
    assign len_eff   = is_byte ? 7'd8 : len_clamp;
    assign pos0      = is_byte ? {1'b0, byte_index, 3'b000} : {1'b0, bit_offset};
    assign pos_end   = pos0 + {3'b000, len_eff} - 10'd1;
    assign fl13      = {6'd0, frame_length};
    assign lim_in    = is_byte ? FB : ((fl13 < FB) ? fl13 : FB);

    // current byte slice
    assign lo        = (cur_reg == first_reg) ? slo_reg : 3'd0;
    assign hi        = (cur_reg == last_reg) ? elo_reg : 3'd7;
    assign n_cur     = {1'b0, hi} - {1'b0, lo} + 4'd1;
    assign sh_cur    = 3'd7 - hi;
    assign inlim_cur = {6'd0, cur_reg} < lim_reg;
    assign addr_wide = {{AW{1'b0}}, cur_reg};
    assign addr_cur  = addr_wide[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE, ST_DONE:
            begin
                if (accept)
                begin
                    state_next = (len_eff == 7'd0) ? ST_DONE : ST_RUN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (cur_reg == stop_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next      = cur_reg;
        stop_next     = stop_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        slo_next      = slo_reg;
        elo_next      = elo_reg;
        lim_next      = lim_reg;
        get_next      = get_reg;
        s1_valid_next = (state_reg == ST_RUN);
        s1_sh_next    = sh_cur;
        s1_n_next     = n_cur;
        s1_inlim_next = inlim_cur;
        s1_addr_next  = addr_cur;
        if (accept)
        begin
            first_next = pos0[POS_W-1:3];
            last_next  = pos_end[POS_W-1:3];
            slo_next   = pos0[2:0];
            elo_next   = pos_end[2:0];
            lim_next   = lim_in;
            get_next   = is_get;
            // extract walks forward, insert walks back from the last byte
            cur_next   = is_get ? pos0[POS_W-1:3] : pos_end[POS_W-1:3];
            stop_next  = is_get ? pos_end[POS_W-1:3] : pos0[POS_W-1:3];
        end
        else if (state_reg == ST_RUN && cur_reg != stop_reg)
        begin
            cur_next = get_reg ? cur_reg + 7'd1 : cur_reg - 7'd1;
        end
    end

    always_comb
    begin
        busy      = (state_reg == ST_RUN) || (state_reg == ST_DRAIN);
        done      = (state_reg == ST_DONE);
        rd_en     = (state_reg == ST_RUN) && inlim_cur;
        rd_addr   = addr_cur;
        wr_en     = s1_valid_reg && !get_reg && s1_inlim_reg;
        wr_addr   = s1_addr_reg;
        ctl.init  = accept;
        ctl.proc  = s1_valid_reg;
        ctl.get   = get_reg;
        ctl.sh    = s1_sh_reg;
        ctl.n     = s1_n_reg;
        ctl.inlim = s1_inlim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s1_valid_reg <= 1'b0;
            get_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            get_reg      <= get_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        stop_reg     <= stop_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        slo_reg      <= slo_next;
        elo_reg      <= elo_next;
        lim_reg      <= lim_next;
        s1_sh_reg    <= s1_sh_next;
        s1_n_reg     <= s1_n_next;
        s1_inlim_reg <= s1_inlim_next;
        s1_addr_reg  <= s1_addr_next;
    end

    `FBA_ASSERT_NEXT(a_accept_moves, accept, busy || done, "accepted word left no trace")
    `FBA_ASSERT_NOW(a_port_clash, wr_en && rd_en, wr_addr != rd_addr, "read and write same byte")
    `FBA_ASSERT_NOW(a_write_on_get, wr_en, !get_reg, "store written during an extract")
    `FBA_ASSERT_NEXT(a_drain_done, state_reg == ST_DRAIN, done, "drain not followed by strobe")

endmodule

FILE: rtl/frame_bit_field_access.sv
// Frame bit field access: byte store holding one frame, with byte load/read
// and MSB-first bit field get/set. After accept the sequencer walks RUN over
// the stored bytes touched (1..5 for fields, 1 for byte actions), then DRAIN,
// then DONE, where done is high; a zero-length field goes straight to DONE.
// A new word is taken in IDLE or in the done cycle, not while busy; no stall
// from the receiver. Reset: frame_length to 64, sequencer idle, store undefined.
module frame_bit_field_access
    import fba_pkg::*;
#(
    parameter int FRAME_BYTES    = FRAME_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // frame length register
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // command word
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [5:0]  byte_index,
    input  logic [7:0]  byte_value,
    input  logic [8:0]  bit_offset,
    input  logic [5:0]  field_length,
    input  logic [31:0] field_value,
    // result word, valid while done is high
    output logic        done,
    output logic [31:0] read_data
);

    localparam int AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int ACC_W = (MAX_FIELD_BITS > 8) ? MAX_FIELD_BITS : 8;

    logic [6:0]       frame_length_reg, frame_length_next;
    ctl_t             ctl;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       rd_data;
    logic [7:0]       wr_data;
    logic [31:0]      val32;
    logic [ACC_W-1:0] init_value;

    // frame length register; the user must write it only while idle, the block does not enforce it
    assign frame_length_next = cfg_wr_en ? cfg_wr_data : frame_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LEN_RESET;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
        end
    end

    // load byte becomes an 8-bit insert at byte_index*8
    assign val32      = (action == ACT_LOAD) ? {24'd0, byte_value} : field_value;
    assign init_value = ACC_W'(val32);

    fba_seq #(
        .FRAME_BYTES    (FRAME_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .byte_index   (byte_index),
        .bit_offset   (bit_offset),
        .field_length (field_length),
        .frame_length (frame_length_reg),
        .busy         (busy),
        .done         (done),
        .ctl          (ctl),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr)
    );

    fba_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fba_slice #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_slice (
        .clk        (clk),
        .ctl        (ctl),
        .init_value (init_value),
        .rd_data    (rd_data),
        .wr_data    (wr_data),
        .read_data  (read_data)
    );

endmodule
